### rtl/qat_pkg.sv
package qat_pkg;

    // Fixed field widths of the character and count paths.
    localparam int CHAR_WIDTH  = 16;
    localparam int COUNT_WIDTH = 32;
    localparam int CFG_INDEX_WIDTH = 1;
    localparam int CFG_DATA_WIDTH  = 16;

    // Input commands.
    localparam logic [1:0] CMD_CHAR   = 2'd0;
    localparam logic [1:0] CMD_EOI    = 2'd1;
    localparam logic [1:0] CMD_CLEAR  = 2'd2;

    // Split modes. The unused code behaves as whole-line mode.
    localparam logic [1:0] MODE_DELIMITED = 2'd0;
    localparam logic [1:0] MODE_SPLIT     = 2'd1;
    localparam logic [1:0] MODE_LINE      = 2'd2;

    // Configuration register indexes.
    localparam logic [CFG_INDEX_WIDTH-1:0] REG_SPLIT_MODE = 1'b0;
    localparam logic [CFG_INDEX_WIDTH-1:0] REG_DELIMITER  = 1'b1;

    // Result kinds.
    localparam logic KIND_CHAR = 1'b0;
    localparam logic KIND_END  = 1'b1;

    // Character codes with a special meaning in the escaped modes.
    localparam logic [CHAR_WIDTH-1:0] C_BACKSLASH = CHAR_WIDTH'(16'h005C);
    localparam logic [CHAR_WIDTH-1:0] C_DQUOTE    = CHAR_WIDTH'(16'h0022);
    localparam logic [CHAR_WIDTH-1:0] C_SQUOTE    = CHAR_WIDTH'(16'h0027);
    localparam logic [CHAR_WIDTH-1:0] C_NEWLINE   = CHAR_WIDTH'(16'h000A);
    localparam logic [CHAR_WIDTH-1:0] C_TAB       = CHAR_WIDTH'(16'h0009);
    localparam logic [CHAR_WIDTH-1:0] C_BLANK     = CHAR_WIDTH'(16'h0020);

    // Reset values of the configuration registers.
    localparam logic [1:0]            SPLIT_MODE_RESET = MODE_SPLIT;
    localparam logic [CHAR_WIDTH-1:0] DELIMITER_RESET  = C_NEWLINE;

    typedef enum logic [1:0] {
        PH_SKIP   = 2'd0,
        PH_TOKEN  = 2'd1,
        PH_QUOTED = 2'd2,
        PH_ESCAPE = 2'd3
    } phase_t;

    typedef struct packed {
        logic [1:0]            cmd;
        logic [CHAR_WIDTH-1:0] ch;
    } in_item_t;

    typedef struct packed {
        logic                   kind;
        logic [CHAR_WIDTH-1:0]  out_char;
        logic [COUNT_WIDTH-1:0] line_total;
        logic [COUNT_WIDTH-1:0] token_total;
    } out_item_t;

    typedef struct packed {
        logic [1:0]            split_mode;
        logic [CHAR_WIDTH-1:0] delimiter_char;
    } cfg_t;

    typedef struct packed {
        phase_t                 phase;
        logic [CHAR_WIDTH-1:0]  quote_mark;
        logic                   token_seen;
        logic [COUNT_WIDTH-1:0] line_count;
        logic [COUNT_WIDTH-1:0] token_count;
    } tok_state_t;

endpackage

### rtl/qat_in_stage.sv
module qat_in_stage (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_stall,
    input  qat_pkg::in_item_t in_data,
    input  logic              advance,
    output logic              item_valid,
    output qat_pkg::in_item_t item
);

    logic              valid_reg;
    logic              valid_next;
    qat_pkg::in_item_t item_reg;
    logic              take;

    // The register is free when empty or when its item moves on this cycle.
    assign in_stall   = valid_reg && !advance;
    assign take       = in_valid && !in_stall;
    assign valid_next = take || (valid_reg && !advance);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            item_reg <= in_data;
        end
    end

    assign item_valid = valid_reg;
    assign item       = item_reg;

endmodule

### rtl/qat_step.sv
module qat_step (
    input  qat_pkg::cfg_t       cfg,
    input  qat_pkg::tok_state_t st,
    input  qat_pkg::in_item_t   item,
    output qat_pkg::tok_state_t st_next,
    output logic                res_valid,
    output qat_pkg::out_item_t  res
);

    logic is_blank;
    logic is_ws;
    logic do_end;
    logic end_line;
    logic do_keep;
    logic do_emit;

    assign is_blank = (item.ch == qat_pkg::C_BLANK) || (item.ch == qat_pkg::C_TAB);
    assign is_ws    = is_blank || (item.ch == qat_pkg::C_NEWLINE);

    always_comb
    begin
        st_next  = st;
        do_end   = 1'b0;
        end_line = 1'b0;
        do_keep  = 1'b0;
        do_emit  = 1'b0;

        unique case (item.cmd)
            qat_pkg::CMD_CLEAR:
            begin
                st_next.line_count  = '0;
                st_next.token_count = '0;
            end
            qat_pkg::CMD_EOI:
            begin
                // A pending escape or quoted span is dropped.
                st_next.phase      = qat_pkg::PH_SKIP;
                st_next.token_seen = 1'b0;
                do_end             = st.token_seen;
                end_line           = (cfg.split_mode == qat_pkg::MODE_DELIMITED);
            end
            qat_pkg::CMD_CHAR:
            begin
                if (cfg.split_mode == qat_pkg::MODE_DELIMITED)
                begin
                    if (item.ch == cfg.delimiter_char)
                    begin
                        do_end   = 1'b1;
                        end_line = 1'b1;
                    end
                    else
                    begin
                        st_next.phase = qat_pkg::PH_TOKEN;
                        do_keep       = 1'b1;
                    end
                end
                else
                begin
                    unique case (st.phase)
                        qat_pkg::PH_ESCAPE:
                        begin
                            st_next.phase = qat_pkg::PH_TOKEN;
                            do_keep       = 1'b1;
                        end
                        qat_pkg::PH_QUOTED:
                        begin
                            // Even an empty quoted span makes a token.
                            st_next.token_seen = 1'b1;
                            if (item.ch == st.quote_mark)
                            begin
                                st_next.phase = qat_pkg::PH_TOKEN;
                            end
                            else
                            begin
                                do_emit = 1'b1;
                            end
                        end
                        qat_pkg::PH_SKIP, qat_pkg::PH_TOKEN:
                        begin
                            if (!(st.phase == qat_pkg::PH_SKIP && is_ws))
                            begin
                                st_next.phase = qat_pkg::PH_TOKEN;
                                if (is_blank)
                                begin
                                    if (cfg.split_mode == qat_pkg::MODE_SPLIT)
                                    begin
                                        do_end = 1'b1;
                                    end
                                    else
                                    begin
                                        do_keep = 1'b1;
                                    end
                                end
                                else if (item.ch == qat_pkg::C_NEWLINE)
                                begin
                                    do_end   = 1'b1;
                                    end_line = 1'b1;
                                end
                                else if (item.ch == qat_pkg::C_BACKSLASH)
                                begin
                                    st_next.phase = qat_pkg::PH_ESCAPE;
                                end
                                else if ((item.ch == qat_pkg::C_DQUOTE)
                                      || (item.ch == qat_pkg::C_SQUOTE))
                                begin
                                    st_next.quote_mark = item.ch;
                                    st_next.phase      = qat_pkg::PH_QUOTED;
                                end
                                else
                                begin
                                    do_keep = 1'b1;
                                end
                            end
                        end
                    endcase
                end
            end
            default:
            begin
                // The unused command is ignored.
            end
        endcase

        if (do_end)
        begin
            if (end_line)
            begin
                st_next.line_count = st.line_count + 1'b1;
            end
            st_next.token_count = st.token_count + 1'b1;
            st_next.phase       = qat_pkg::PH_SKIP;
            st_next.token_seen  = 1'b0;
        end
        if (do_keep)
        begin
            st_next.token_seen = 1'b1;
        end

        res_valid       = do_end || do_keep || do_emit;
        res.kind        = do_end ? qat_pkg::KIND_END : qat_pkg::KIND_CHAR;
        res.out_char    = do_end ? '0 : item.ch;
        res.line_total  = st_next.line_count;
        res.token_total = st_next.token_count;
    end

endmodule

### rtl/quoted_argument_tokenizer.sv
// Quoted argument tokenizer.
//
// Input channel (in_valid, in_stall, in_data): one transfer per item, either
// a character, an end-of-input command or a command that clears both counts.
// Output channel (out_valid, out_stall, out_data): one transfer per kept
// character or token-end marker; each result carries the line and token
// counts as they stand after that item. Items that only change state (count
// clears; in escaped modes leading whitespace, quotes, backslashes) give no transfer.
// Configuration channel (cfg_valid, cfg_ready, cfg_index, cfg_data): writes
// split_mode (index 0) and delimiter_char (index 1); it is always ready and
// is meant to be written only while the block is empty.
//
// Each input transfer passes through two registers on its way to the output:
// the input register, then the result register. Throughput is one item per
// clock while the receiver does not stall, set by the tokenizer state update.
// When the receiver stalls a waiting result, the result register holds and
// in_stall rises at once if the input register is full, one item later if not.
// Reset empties both registers, clears the counts and the token state, and
// loads split_mode = 1 and delimiter_char = newline.
module quoted_argument_tokenizer (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   in_valid,
    output logic                                   in_stall,
    input  qat_pkg::in_item_t                      in_data,
    output logic                                   out_valid,
    input  logic                                   out_stall,
    output qat_pkg::out_item_t                     out_data,
    input  logic                                   cfg_valid,
    output logic                                   cfg_ready,
    input  logic [qat_pkg::CFG_INDEX_WIDTH-1:0]    cfg_index,
    input  logic [qat_pkg::CFG_DATA_WIDTH-1:0]     cfg_data
);

    qat_pkg::cfg_t       cfg_reg;
    qat_pkg::tok_state_t st_reg;
    qat_pkg::tok_state_t st_next;
    logic                out_valid_reg;
    qat_pkg::out_item_t  out_reg;

    logic                item_valid;
    qat_pkg::in_item_t   item;
    logic                advance;
    logic                fire;
    logic                res_valid;
    qat_pkg::out_item_t  res;

    // The item in the input register moves on whenever the result register
    // is empty or its current result is being taken.
    assign advance = !out_valid_reg || !out_stall;
    assign fire    = advance && item_valid;

    qat_in_stage u_in_stage (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .in_data    (in_data),
        .advance    (advance),
        .item_valid (item_valid),
        .item       (item)
    );

    qat_step u_step (
        .cfg       (cfg_reg),
        .st        (st_reg),
        .item      (item),
        .st_next   (st_next),
        .res_valid (res_valid),
        .res       (res)
    );

    assign cfg_ready = 1'b1;

    // Configuration registers; a write takes effect on the next item.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.split_mode     <= qat_pkg::SPLIT_MODE_RESET;
            cfg_reg.delimiter_char <= qat_pkg::DELIMITER_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            if (cfg_index == qat_pkg::REG_SPLIT_MODE)
            begin
                cfg_reg.split_mode <= cfg_data[1:0];
            end
            else
            begin
                cfg_reg.delimiter_char <= cfg_data[qat_pkg::CHAR_WIDTH-1:0];
            end
        end
    end

    // Tokenizer state advances once per item leaving the input register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg.phase       <= qat_pkg::PH_SKIP;
            st_reg.quote_mark  <= '0;
            st_reg.token_seen  <= 1'b0;
            st_reg.line_count  <= '0;
            st_reg.token_count <= '0;
        end
        else if (fire)
        begin
            st_reg <= st_next;
        end
    end

    // Result register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= item_valid && res_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (fire && res_valid)
        begin
            out_reg <= res;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

endmodule

### rtl/qat_checker.sv
module qat_checker (
    input logic               clk,
    input logic               rst_n,
    input logic               in_valid,
    input logic               in_stall,
    input qat_pkg::in_item_t  in_data,
    input logic               out_valid,
    input logic               out_stall,
    input qat_pkg::out_item_t out_data,
    input logic               cfg_valid,
    input logic               cfg_ready
);

    // A stalled result stays and does not change.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("stalled result changed or was dropped");

    // The sender keeps a stalled item unchanged.
    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_stall |=> in_valid && $stable(in_data))
    else $error("stalled input item changed or was withdrawn");

    // A token-end marker carries no character.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (out_data.kind == qat_pkg::KIND_END) |-> (out_data.out_char == '0))
    else $error("token end marker carries a character");

    // No result can be pending right after reset is released.
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(rst_n) |-> !out_valid)
    else $error("result present right after reset");

    // The configuration port never holds off a write.
    assert property (@(posedge clk) disable iff (!rst_n)
        cfg_valid |-> cfg_ready)
    else $error("configuration write held off");

endmodule

bind quoted_argument_tokenizer qat_checker u_qat_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready)
);
